// File: hw/rtl/hfe_pkg.sv
// ----------------------------------------------------------------------------
// hfe_pkg: shared types, constants and the byte table for the frame encoder
// Item descriptor passed from the frame control stage to the byte sequencer,
// and the byte lookup used for every slot of every frame kind.
// ----------------------------------------------------------------------------
`default_nettype none

package hfe_pkg;

    typedef enum logic [1:0] {
        ACT_PAYLOAD = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_NACK    = 2'd2,
        ACT_ERR     = 2'd3
    } action_t;

    localparam int unsigned IDX_W = 4;
    typedef logic [IDX_W-1:0] idx_t;

    // payload frame slots
    localparam idx_t SLOT_PRE0      = 4'd0;
    localparam idx_t SLOT_PRE1      = 4'd1;
    localparam idx_t SLOT_START     = 4'd2;
    localparam idx_t SLOT_LEN       = 4'd3;
    localparam idx_t SLOT_LCS       = 4'd4;
    localparam idx_t SLOT_TFI       = 4'd5;
    localparam idx_t SLOT_DATA      = 4'd6;
    localparam idx_t SLOT_DCS       = 4'd7;
    localparam idx_t SLOT_POSTAMBLE = 4'd8;

    // last slot of the fixed control frames
    localparam idx_t SLOT_ACK_END   = 4'd5;
    localparam idx_t SLOT_ERR_END   = 4'd7;

    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_START = 8'hFF;
    localparam logic [7:0] HOST_TFI   = 8'hD4;
    localparam logic [7:0] ERR_LEN    = 8'h01;
    localparam logic [7:0] ERR_TFI    = 8'h7F;
    localparam logic [7:0] ERR_DCS    = 8'h81;

    typedef struct packed {
        action_t    action;
        logic [7:0] data;
        logic [7:0] len;
        logic [7:0] dcs;
        idx_t       start_idx;
        idx_t       end_idx;
    } item_t;

    function automatic logic [7:0] byte_at(input action_t a, input idx_t idx,
                                           input logic [7:0] len,
                                           input logic [7:0] data,
                                           input logic [7:0] dcs);
        logic [7:0] b;
        b = BYTE_ZERO;
        unique case (a)
            ACT_PAYLOAD: begin
                case (idx)
                    SLOT_START: b = BYTE_START;
                    SLOT_LEN:   b = len;
                    SLOT_LCS:   b = 8'(~len + 8'd1);
                    SLOT_TFI:   b = HOST_TFI;
                    SLOT_DATA:  b = data;
                    SLOT_DCS:   b = dcs;
                    default:    b = BYTE_ZERO;
                endcase
            end
            ACT_ACK: begin
                case (idx)
                    4'd2, 4'd4: b = BYTE_START;
                    default:    b = BYTE_ZERO;
                endcase
            end
            ACT_NACK: begin
                case (idx)
                    4'd2, 4'd3: b = BYTE_START;
                    default:    b = BYTE_ZERO;
                endcase
            end
            ACT_ERR: begin
                case (idx)
                    4'd2, 4'd4: b = BYTE_START;
                    4'd3:       b = ERR_LEN;
                    4'd5:       b = ERR_TFI;
                    4'd6:       b = ERR_DCS;
                    default:    b = BYTE_ZERO;
                endcase
            end
            default: b = BYTE_ZERO;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hfe_frame_ctl.sv
// ----------------------------------------------------------------------------
// hfe_frame_ctl: frame state and item register
// Tracks bytes left and the running payload sum, and latches one item
// descriptor per accepted input transaction for the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module hfe_frame_ctl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  hfe_pkg::action_t    in_action,
    input  wire [7:0]           in_data,
    input  wire [7:0]           in_length,
    output logic                item_valid,
    output hfe_pkg::item_t      item,
    input  wire                 item_take
);

    logic           item_valid_reg, item_valid_next;
    hfe_pkg::item_t item_reg, item_next;
    logic [7:0]     bytes_left_reg, bytes_left_next;
    logic [7:0]     running_sum_reg, running_sum_next;

    logic       accept;
    logic       first;
    logic [7:0] plen_eff;
    logic [7:0] bl_cur;
    logic [7:0] bl_dec;
    logic [7:0] new_sum;
    logic [7:0] total;

    assign in_ready   = !item_valid_reg || item_take;
    assign accept     = in_valid && in_ready;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    always_comb begin
        first    = (bytes_left_reg == 8'd0);
        plen_eff = (in_length == 8'd0) ? 8'd1 : in_length;
        bl_cur   = first ? plen_eff : bytes_left_reg;
        bl_dec   = bl_cur - 8'd1;
        new_sum  = (first ? 8'd0 : running_sum_reg) + in_data;
        total    = hfe_pkg::HOST_TFI + new_sum;

        item_valid_next  = item_valid_reg;
        item_next        = item_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;

        if (accept) begin
            item_valid_next     = 1'b1;
            item_next.action    = in_action;
            item_next.data      = in_data;
            item_next.len       = plen_eff + 8'd1;
            item_next.dcs       = 8'(~total + 8'd1);
            item_next.start_idx = hfe_pkg::SLOT_PRE0;
            unique case (in_action) inside
                hfe_pkg::ACT_PAYLOAD: begin
                    item_next.start_idx = first ? hfe_pkg::SLOT_PRE0 : hfe_pkg::SLOT_DATA;
                    item_next.end_idx   = (bl_dec == 8'd0) ? hfe_pkg::SLOT_POSTAMBLE
                                                           : hfe_pkg::SLOT_DATA;
                    bytes_left_next     = bl_dec;
                    running_sum_next    = (bl_dec == 8'd0) ? 8'd0 : new_sum;
                end
                hfe_pkg::ACT_ACK, hfe_pkg::ACT_NACK: begin
                    item_next.end_idx = hfe_pkg::SLOT_ACK_END;
                end
                hfe_pkg::ACT_ERR: begin
                    item_next.end_idx = hfe_pkg::SLOT_ERR_END;
                end
                default: begin
                    item_next.end_idx = hfe_pkg::SLOT_ERR_END;
                end
            endcase
        end else if (item_take) begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg  <= 1'b0;
            bytes_left_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
        end else begin
            item_valid_reg  <= item_valid_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

`ifndef ASSERT_OFF
    // with no frame open the sum must have been cleared
    a_sum_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg == 8'd0 |-> running_sum_reg == 8'd0)
        else $error("running sum not cleared outside a frame");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> item_valid_reg)
        else $error("accepted transaction did not load the item register");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/hfe_byte_seq.sv
// ----------------------------------------------------------------------------
// hfe_byte_seq: byte sequencer and output register
// Walks the slots of the held item into the output register, one byte per
// cycle unless the output stalls, and releases the item on its last slot.
// ----------------------------------------------------------------------------
`default_nettype none

module hfe_byte_seq (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 item_valid,
    input  hfe_pkg::item_t      item,
    output logic                item_take,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [7:0]          out_byte,
    output logic                out_end
);

    logic                busy_reg, busy_next;
    hfe_pkg::idx_t       idx_reg, idx_next;
    logic                valid_reg, valid_next;
    logic [7:0]          byte_reg, byte_next;
    logic                end_reg, end_next;

    hfe_pkg::idx_t cur_idx;
    logic          out_load;
    logic          at_end;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_end   = end_reg;

    always_comb begin
        cur_idx   = busy_reg ? idx_reg : item.start_idx;
        out_load  = item_valid && (!valid_reg || out_ready);
        at_end    = (cur_idx == item.end_idx);
        item_take = out_load && at_end;

        busy_next  = busy_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;

        if (out_load) begin
            valid_next = 1'b1;
            byte_next  = hfe_pkg::byte_at(item.action, cur_idx, item.len, item.data,
                                          item.dcs);
            // payload items that end on the data slot leave the frame open
            end_next   = at_end && (item.end_idx != hfe_pkg::SLOT_DATA);
            busy_next  = !at_end;
            idx_next   = cur_idx + hfe_pkg::idx_t'(1);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

`ifndef ASSERT_OFF
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid |-> cur_idx <= item.end_idx)
        else $error("slot index ran past the end of the item");

    a_busy_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> item_valid)
        else $error("sequencer mid-item with no item held");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/host_frame_encoder.sv
// ----------------------------------------------------------------------------
// host_frame_encoder: host command to framed transmit byte stream
// Accepts payload and control transactions and emits one byte per output
// transaction, with tlast on the postamble closing each frame.
// ----------------------------------------------------------------------------
// One output byte leaves per cycle while the receiver does not stall. A
// payload byte in the middle of a frame produces 1 output byte, the first
// byte of a frame 7, the last byte 3 and a one-byte frame 9; ACK and NACK
// produce 6 bytes and the application-error frame 8. An item register in
// front of the byte sequencer holds the current transaction, and the next
// is accepted in the same cycle as the current one's last byte enters the
// output register. The output register holds a byte under back-pressure,
// which stalls the sequencer and, while an item is held, the input side.
`default_nettype none

module host_frame_encoder (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [1:0] action, [9:2] payload_byte, [17:10] payload_length, [23:18] zero
    input  wire [23:0]  s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [7:0] out_byte
    output logic [7:0]  m_tdata,
    // frame_end
    output logic        m_tlast
);

    logic           item_valid;
    logic           item_take;
    hfe_pkg::item_t item;

    hfe_frame_ctl u_ctl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (hfe_pkg::action_t'(s_tdata[1:0])),
        .in_data    (s_tdata[9:2]),
        .in_length  (s_tdata[17:10]),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    hfe_byte_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_end    (m_tlast)
    );

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for host_frame_encoder
// Drives payload and control transactions with bursty timing against a
// receiver that stalls on a rotating pattern. Every accepted command is run
// through a local frame builder, and each output byte is checked in order
// against the bytes it predicted, including tlast on each postamble.
// ----------------------------------------------------------------------------

module tb;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES = 32;
    localparam int unsigned PRINT_LIMIT = 20;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } tx_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // frame builder state
    logic [7:0]  frame_bytes_left = '0;
    logic [7:0]  frame_sum        = '0;
    tx_byte_t    tx_bytes_due[$];

    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;
    bit          sender_gaps    = 1'b1;

    host_frame_encoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void push_tx_byte(input logic [7:0] value, input logic last);
        tx_byte_t b;
        b.value = value;
        b.last  = last;
        tx_bytes_due.push_back(b);
    endfunction

    // six bytes; last5 is tlast on the sixth
    function automatic void push_tx_frame(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [7:0] b4, input logic [7:0] b5,
                                          input logic last5);
        push_tx_byte(b0, 1'b0);
        push_tx_byte(b1, 1'b0);
        push_tx_byte(b2, 1'b0);
        push_tx_byte(b3, 1'b0);
        push_tx_byte(b4, 1'b0);
        push_tx_byte(b5, last5);
    endfunction

    // bytes a command puts on the link, and the frame state it leaves behind
    function automatic void predict_tx(input hfe_pkg::action_t act, input logic [7:0] data,
                                       input logic [7:0] plen);
        logic [7:0] count;
        logic [7:0] len_field;
        case (act)
            hfe_pkg::ACT_ACK: begin
                push_tx_frame(8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1);
            end
            hfe_pkg::ACT_NACK: begin
                push_tx_frame(8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1);
            end
            hfe_pkg::ACT_ERR: begin
                push_tx_frame(8'h00, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'h7F, 1'b0);
                push_tx_byte(8'h81, 1'b0);
                push_tx_byte(8'h00, 1'b1);
            end
            default: begin
                if (frame_bytes_left == 8'd0) begin
                    // a zero length opens a one-byte frame
                    count     = (plen == 8'd0) ? 8'd1 : plen;
                    len_field = count + 8'd1;
                    push_tx_frame(8'h00, 8'h00, 8'hFF, len_field,
                                  8'(8'd0 - len_field), 8'hD4, 1'b0);
                    frame_bytes_left = count;
                    frame_sum        = 8'd0;
                end
                push_tx_byte(data, 1'b0);
                frame_sum        = frame_sum + data;
                frame_bytes_left = frame_bytes_left - 8'd1;
                if (frame_bytes_left == 8'd0) begin
                    push_tx_byte(8'(8'd0 - (8'hD4 + frame_sum)), 1'b0);
                    push_tx_byte(8'h00, 1'b1);
                    frame_sum = 8'd0;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] expected,
                                   input logic [7:0] got);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch on %s: expected %02h, got %02h",
                     $realtime, what, expected, got);
        mismatch_count++;
    endtask

    // one command transaction, with the sender's burst and gap timing
    task automatic send_command(input hfe_pkg::action_t act, input logic [7:0] data,
                                input logic [7:0] plen);
        if (burst_left == 0) begin
            if (sender_gaps) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left = 64;
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, plen, data, act};
        do @(posedge aclk); while (!s_tready);
        predict_tx(act, data, plen);
        burst_left--;
    endtask

    task automatic send_control();
        send_command(hfe_pkg::action_t'($urandom_range(1, 3)), 8'($urandom),
                     8'($urandom));
    endtask

    // sender holds off until the link has caught up
    task automatic wait_tx_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (tx_bytes_due.size() != 0);
    endtask

    task automatic test_control_frames();
        send_command(hfe_pkg::ACT_ACK,  8'hFF, 8'hFF);
        send_command(hfe_pkg::ACT_NACK, 8'h00, 8'h00);
        send_command(hfe_pkg::ACT_ERR,  8'hA5, 8'h5A);
        send_command(hfe_pkg::ACT_ACK,  8'h00, 8'h00);
    endtask

    task automatic test_edge_lengths();
        // single-byte frame, then zero length treated as one
        send_command(hfe_pkg::ACT_PAYLOAD, 8'h00, 8'd1);
        send_command(hfe_pkg::ACT_PAYLOAD, 8'hFF, 8'd0);
        // length is only sampled on the first byte
        send_command(hfe_pkg::ACT_PAYLOAD, 8'hFF, 8'd2);
        send_command(hfe_pkg::ACT_PAYLOAD, 8'h80, 8'hFF);
        // controls inside an open frame leave it intact
        send_command(hfe_pkg::ACT_PAYLOAD, 8'h12, 8'd3);
        send_command(hfe_pkg::ACT_ACK,     8'h00, 8'h00);
        send_command(hfe_pkg::ACT_PAYLOAD, 8'h34, 8'd1);
        send_command(hfe_pkg::ACT_NACK,    8'hFF, 8'hFF);
        send_command(hfe_pkg::ACT_ERR,     8'h55, 8'h01);
        send_command(hfe_pkg::ACT_PAYLOAD, 8'hFE, 8'h00);
        wait_tx_drained();
    endtask

    // length 255 wraps LEN and LCS to zero; the sum wraps many times over
    task automatic test_long_frame();
        send_command(hfe_pkg::ACT_PAYLOAD, 8'($urandom), 8'd255);
        for (int i = 1; i < 255; i++) begin
            if (i % 64 == 0)
                sender_gaps = !sender_gaps;
            if ($urandom_range(0, 49) == 0)
                send_control();
            send_command(hfe_pkg::ACT_PAYLOAD, 8'($urandom), 8'($urandom));
        end
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned pick;
        int unsigned plen;
        sent = 0;
        while (sent < 120) begin
            if ($urandom_range(0, 7) == 0)
                sender_gaps = !sender_gaps;
            if ($urandom_range(0, 5) == 0) begin
                send_control();
                sent++;
            end else begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    plen = 0;
                else if (pick == 1)
                    plen = $urandom_range(9, 40);
                else
                    plen = $urandom_range(1, 8);
                send_command(hfe_pkg::ACT_PAYLOAD, 8'($urandom), 8'(plen));
                sent++;
                while (frame_bytes_left != 8'd0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_control();
                        sent++;
                    end
                    send_command(hfe_pkg::ACT_PAYLOAD, 8'($urandom), 8'($urandom));
                    sent++;
                end
            end
        end
        sender_gaps = 1'b1;
    endtask

    // receiver stall pattern, reloaded with a randomly chosen pattern
    logic [15:0] ready_pattern = 16'hFFFF;
    int unsigned pattern_age   = 0;

    always @(posedge aclk) begin
        if (pattern_age == 47) begin
            pattern_age = 0;
            case ($urandom_range(0, 3))
                0:       ready_pattern = 16'hFFFF;
                1:       ready_pattern = 16'($urandom & $urandom) | 16'h8000;
                default: ready_pattern = 16'($urandom) | 16'h0001;
            endcase
        end else begin
            pattern_age++;
        end
        m_tready      <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    tx_byte_t tx_head;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (tx_bytes_due.size() == 0) begin
                report_mismatch("unexpected byte", 8'h00, m_tdata);
            end else begin
                tx_head = tx_bytes_due.pop_front();
                if (m_tdata !== tx_head.value)
                    report_mismatch("out_byte", tx_head.value, m_tdata);
                if (m_tlast !== tx_head.last)
                    report_mismatch("frame_end", 8'(tx_head.last), 8'(m_tlast));
            end
        end
    end

    // no transaction on either side for too long means the block has hung
    int unsigned idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_control_frames();
        test_edge_lengths();
        test_long_frame();
        wait_tx_drained();
        test_random_traffic();
        wait_tx_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && tx_bytes_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: host_frame_encoder.f
hw/rtl/hfe_pkg.sv
hw/rtl/hfe_frame_ctl.sv
hw/rtl/hfe_byte_seq.sv
hw/rtl/host_frame_encoder.sv
sim/tb.sv
